>>> hw/rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// shared types and constants for the rtd ratio to temperature pipeline
// ----------------------------------------------------------------------------
package rtd_pkg;

    typedef enum logic [1:0] {
        STATUS_VALID = 2'd0,
        STATUS_FAULT = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    localparam int unsigned RES_FRAC_BITS_DEFAULT = 16;
    localparam int unsigned RES_INT_BITS          = 10;

    localparam int unsigned FAULT_W = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned REF_W   = 16;
    localparam int unsigned TEMP_W  = 16;
    localparam logic [REF_W-1:0] REF_RES_RESET = 16'd43000;

    // code is the data word without its flag bit, full scale 2^15
    localparam int unsigned CODE_W = 15;
    localparam int unsigned X_W    = CODE_W + REF_W;
    localparam int unsigned Q_W    = 25;
    localparam int unsigned REM_W  = 7;

    localparam logic [6:0] HUNDRED = 7'd100;

    // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^31
    localparam int unsigned RECIP_W     = 32;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_100 = 32'd2748779070;

    // floor(v / 100) for v < 2^16
    localparam int unsigned REM_SCALED_W     = 16;
    localparam int unsigned FRAC_RECIP_W     = 17;
    localparam int unsigned FRAC_RECIP_SHIFT = 23;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = 17'd83887;

    localparam int unsigned ACC_W          = 56;
    localparam int unsigned ACC_LO_W       = 28;
    localparam int unsigned COEF_FRAC_BITS = 40;
    localparam int unsigned POLY_ORDER     = 5;

    localparam logic signed [ACC_W-1:0] POLY_COEF [POLY_ORDER+1] = '{
        -56'sd266103804154348,
         56'sd2443994446220,
         56'sd2843227118,
        -56'sd5306243,
        -56'sd30988,
         56'sd168
    };

    localparam int unsigned MUL10_W = ACC_W + 4;
    localparam int unsigned TQ_W    = MUL10_W - COEF_FRAC_BITS;
    localparam int TEMP_MAX = 32767;
    localparam int TEMP_MIN = -32768;

endpackage

>>> hw/rtl/rtd_horner_step.sv
// ----------------------------------------------------------------------------
// rtd_horner_step
// one horner step, acc * r truncated toward zero plus coefficient, 3 stages
// ----------------------------------------------------------------------------
module rtd_horner_step #(
    parameter int unsigned RES_FRAC_BITS = rtd_pkg::RES_FRAC_BITS_DEFAULT,
    parameter logic signed [rtd_pkg::ACC_W-1:0] COEF = '0
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic signed [rtd_pkg::ACC_W-1:0]                 acc_in,
    input  logic [RES_FRAC_BITS+rtd_pkg::RES_INT_BITS-1:0]   res_in,
    input  rtd_pkg::status_t                                 status_in,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic signed [rtd_pkg::ACC_W-1:0]                 acc_out,
    output logic [RES_FRAC_BITS+rtd_pkg::RES_INT_BITS-1:0]   res_out,
    output rtd_pkg::status_t                                 status_out
);
    import rtd_pkg::*;

    localparam int unsigned RES_W  = RES_FRAC_BITS + RES_INT_BITS;
    localparam int unsigned HI_W   = ACC_W - ACC_LO_W;
    localparam int unsigned PHI_W  = HI_W + RES_W + 1;
    localparam int unsigned PLO_W  = ACC_LO_W + RES_W;
    localparam int unsigned PROD_W = ACC_W + RES_W + 1;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic en_a, en_b, en_c;

    logic signed [HI_W-1:0]   acc_hi;
    logic [ACC_LO_W-1:0]      acc_lo;
    logic signed [RES_W:0]    res_signed;
    logic signed [PHI_W-1:0]  phi_next, phi_reg;
    logic [PLO_W-1:0]         plo_next, plo_reg;
    logic [RES_W-1:0]         a_res_reg, b_res_reg, c_res_reg;
    status_t                  a_status_reg, b_status_reg, c_status_reg;

    logic signed [PROD_W-1:0] phi_ext, plo_ext, prod_next, prod_reg;
    logic signed [PROD_W-1:0] quot;
    logic                     round_up;
    logic signed [ACC_W-1:0]  acc_next, acc_reg;

    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // split multiply, signed high half and unsigned low half
    assign acc_hi     = acc_in[ACC_W-1:ACC_LO_W];
    assign acc_lo     = acc_in[ACC_LO_W-1:0];
    assign res_signed = {1'b0, res_in};
    assign phi_next   = acc_hi * res_signed;
    assign plo_next   = acc_lo * res_in;

    assign phi_ext   = PROD_W'(phi_reg) <<< ACC_LO_W;
    assign plo_ext   = PROD_W'(plo_reg);
    assign prod_next = phi_ext + plo_ext;

    // floor shift, then bump negative values with dropped bits toward zero
    assign quot     = prod_reg >>> RES_FRAC_BITS;
    assign round_up = prod_reg[PROD_W-1] && (prod_reg[RES_FRAC_BITS-1:0] != '0);
    assign acc_next = quot[ACC_W-1:0] + COEF + {{(ACC_W-1){1'b0}}, round_up};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            phi_reg      <= phi_next;
            plo_reg      <= plo_next;
            a_res_reg    <= res_in;
            a_status_reg <= status_in;
        end
        if (en_b)
        begin
            prod_reg     <= prod_next;
            b_res_reg    <= a_res_reg;
            b_status_reg <= a_status_reg;
        end
        if (en_c)
        begin
            acc_reg      <= acc_next;
            c_res_reg    <= b_res_reg;
            c_status_reg <= b_status_reg;
        end
    end

    assign out_valid  = c_valid_reg;
    assign acc_out    = acc_reg;
    assign res_out    = c_res_reg;
    assign status_out = c_status_reg;

endmodule

>>> hw/rtl/rtd_ratio_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// rtd_ratio_to_temperature_unit
// pt100 converter word to temperature in tenths of a degree, fifth order
// polynomial by horner in fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                      | handshake
//  --------+-----+-----------------------------------+---------------------
//  in      | in  | fault_status, rtd_word            | in_valid / in_ready
//  out     | out | result_status, temperature_tenths | out_valid / out_ready
//  cfg     | in  | cfg_data (reference resistance)   | cfg_valid / cfg_ready
//
//  one beat per cycle sustained while out_ready stays high; the pipeline is
//  the five horner steps of three stages each plus the resistance front
//  end (4) and the scale and saturate tail (2), up to the output register
//  rst_n clears all stage valids and loads reference resistance 43000
//  each stage holds while the next is full, empty stages fill on stall
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module rtd_ratio_to_temperature_unit #(
    parameter int unsigned RESISTANCE_FRACTION_BITS = rtd_pkg::RES_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rtd_pkg::FAULT_W-1:0]         fault_status,
    input  logic [rtd_pkg::WORD_W-1:0]          rtd_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          result_status,
    output logic signed [rtd_pkg::TEMP_W-1:0]   temperature_tenths,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtd_pkg::REF_W-1:0]           cfg_data
);
    import rtd_pkg::*;

    localparam int unsigned RES_W = RESISTANCE_FRACTION_BITS + RES_INT_BITS;
    localparam logic signed [TQ_W-1:0] TQ_MAX = TQ_W'(TEMP_MAX);
    localparam logic signed [TQ_W-1:0] TQ_MIN = TQ_W'(TEMP_MIN);

    logic [REF_W-1:0] ref_res_reg;

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic m_valid_reg, out_valid_reg;
    logic s0_en, s1_en, s2_en, s3_en, m_en, out_en;

    logic [CODE_W-1:0]          code;
    status_t                    status_next;
    logic [X_W-1:0]             x_next, s0_x_reg, s1_x_reg;
    status_t                    s0_status_reg, s1_status_reg, s2_status_reg, s3_status_reg;
    logic [X_W+RECIP_W-1:0]     recip_prod;
    logic [Q_W-1:0]             s1_q_reg, s2_q_reg;
    logic [X_W-1:0]             qx100, rem_full;
    logic [REM_W-1:0]           s2_rem_reg;
    logic [RES_W-1:0]           res_next, s3_res_reg;

    logic                       h_valid  [POLY_ORDER+1];
    logic                       h_ready  [POLY_ORDER+1];
    logic signed [ACC_W-1:0]    h_acc    [POLY_ORDER+1];
    logic [RES_W-1:0]           h_res    [POLY_ORDER+1];
    status_t                    h_status [POLY_ORDER+1];

    logic signed [MUL10_W-1:0]  m_next, m_prod_reg;
    status_t                    m_status_reg, out_status_reg;
    logic signed [MUL10_W-1:0]  tq_full;
    logic                       t_round;
    logic signed [TQ_W-1:0]     tq;
    logic signed [TEMP_W-1:0]   temp_sat, temp_next, out_temp_reg;

    // enable chain from the output back to the input
    assign out_en   = !out_valid_reg || out_ready;
    assign m_en     = !m_valid_reg || out_en;
    assign s3_en    = !s3_valid_reg || h_ready[0];
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s0_en    = !s0_valid_reg || s1_en;
    assign in_ready = s0_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_res_reg <= REF_RES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ref_res_reg <= cfg_data;
        end
    end

    // stage 0: status decode and code times reference
    assign code = rtd_word[WORD_W-1:1];
    assign x_next = code * ref_res_reg;

    always_comb
    begin
        if (fault_status != '0)
        begin
            status_next = STATUS_FAULT;
        end
        else if (code == '0)
        begin
            status_next = STATUS_ZERO;
        end
        else
        begin
            status_next = STATUS_VALID;
        end
    end

    // stage 1: quotient by 100 through reciprocal
    assign recip_prod = s0_x_reg * RECIP_100;

    // stage 2: remainder by 100
    assign qx100    = s1_q_reg * HUNDRED;
    assign rem_full = s1_x_reg - qx100;

    // stage 3: resistance with its fraction bits
    generate
        if (RESISTANCE_FRACTION_BITS > CODE_W) begin : g_frac
            localparam int unsigned FS = RESISTANCE_FRACTION_BITS - CODE_W;
            logic [REM_SCALED_W-1:0]             rem_scaled;
            logic [REM_SCALED_W+FRAC_RECIP_W-1:0] frac_prod;
            assign rem_scaled = REM_SCALED_W'(s2_rem_reg) << FS;
            assign frac_prod  = rem_scaled * FRAC_RECIP;
            assign res_next   = {s2_q_reg, frac_prod[FRAC_RECIP_SHIFT +: FS]};
        end
        else begin : g_trunc
            logic [Q_W-1:0] q_shifted;
            assign q_shifted = s2_q_reg >> (CODE_W - RESISTANCE_FRACTION_BITS);
            assign res_next  = q_shifted[RES_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_en)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_en)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (m_en)
            begin
                m_valid_reg <= h_valid[POLY_ORDER];
            end
            if (out_en)
            begin
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en)
        begin
            s0_x_reg      <= x_next;
            s0_status_reg <= status_next;
        end
        if (s1_en)
        begin
            s1_q_reg      <= recip_prod[RECIP_SHIFT +: Q_W];
            s1_x_reg      <= s0_x_reg;
            s1_status_reg <= s0_status_reg;
        end
        if (s2_en)
        begin
            s2_q_reg      <= s1_q_reg;
            s2_rem_reg    <= rem_full[REM_W-1:0];
            s2_status_reg <= s1_status_reg;
        end
        if (s3_en)
        begin
            s3_res_reg    <= res_next;
            s3_status_reg <= s2_status_reg;
        end
        if (m_en)
        begin
            m_prod_reg    <= m_next;
            m_status_reg  <= h_status[POLY_ORDER];
        end
        if (out_en)
        begin
            out_status_reg <= m_status_reg;
            out_temp_reg   <= temp_next;
        end
    end

    // horner chain, starts from the leading coefficient
    assign h_valid[0]  = s3_valid_reg;
    assign h_acc[0]    = POLY_COEF[POLY_ORDER];
    assign h_res[0]    = s3_res_reg;
    assign h_status[0] = s3_status_reg;
    assign h_ready[POLY_ORDER] = m_en;

    generate
        for (genvar k = 0; k < POLY_ORDER; k++) begin : g_step
            rtd_horner_step #(
                .RES_FRAC_BITS (RESISTANCE_FRACTION_BITS),
                .COEF          (POLY_COEF[POLY_ORDER-1-k])
            ) u_step (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (h_valid[k]),
                .in_ready   (h_ready[k]),
                .acc_in     (h_acc[k]),
                .res_in     (h_res[k]),
                .status_in  (h_status[k]),
                .out_valid  (h_valid[k+1]),
                .out_ready  (h_ready[k+1]),
                .acc_out    (h_acc[k+1]),
                .res_out    (h_res[k+1]),
                .status_out (h_status[k+1])
            );
        end
    endgenerate

    // times ten as shift and add
    assign m_next = (MUL10_W'(h_acc[POLY_ORDER]) <<< 3)
                  + (MUL10_W'(h_acc[POLY_ORDER]) <<< 1);

    // drop coefficient fraction toward zero, saturate, zero unless valid
    assign tq_full = m_prod_reg >>> COEF_FRAC_BITS;
    assign t_round = m_prod_reg[MUL10_W-1] && (m_prod_reg[COEF_FRAC_BITS-1:0] != '0);
    assign tq      = tq_full[TQ_W-1:0] + {{(TQ_W-1){1'b0}}, t_round};

    always_comb
    begin
        if (tq > TQ_MAX)
        begin
            temp_sat = TEMP_W'(TEMP_MAX);
        end
        else if (tq < TQ_MIN)
        begin
            temp_sat = TEMP_W'(TEMP_MIN);
        end
        else
        begin
            temp_sat = tq[TEMP_W-1:0];
        end
        temp_next = (m_status_reg == STATUS_VALID) ? temp_sat : '0;
    end

    assign out_valid          = out_valid_reg;
    assign result_status      = out_status_reg;
    assign temperature_tenths = out_temp_reg;

endmodule

>>> hw/rtl/rtd_chk.sv
// ----------------------------------------------------------------------------
// rtd_chk
// port level checks on the output channel, bound to the top level
// ----------------------------------------------------------------------------
module rtd_chk (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [1:0]                         result_status,
    input  logic signed [rtd_pkg::TEMP_W-1:0]  temperature_tenths
);
    import rtd_pkg::*;

    // stalled beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_status) && $stable(temperature_tenths))
        else $error("out payload changed while stalled");

    // fault and zero-ohm beats carry no temperature
    a_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_status == STATUS_FAULT || result_status == STATUS_ZERO)
        |-> temperature_tenths == '0)
        else $error("temperature nonzero on non-valid status");

    // polynomial floor at zero ohms
    a_temp_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_status == STATUS_VALID |-> temperature_tenths >= -16'sd2421)
        else $error("temperature below polynomial floor");

endmodule

bind rtd_ratio_to_temperature_unit rtd_chk u_rtd_chk (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks rtd_ratio_to_temperature_unit beat by beat against a fixed point
// pt100 predictor: fault and zero code paths, horner polynomial, saturation,
// across several reference resistor settings with random idles and stalls
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtd_pkg::*;

    localparam int unsigned FRAC_BITS     = RES_FRAC_BITS_DEFAULT;
    localparam int unsigned POLY_FRAC     = 40;
    localparam longint      OHM_DIVISOR   = 64'd3276800;
    localparam int          WATCHDOG_MAX  = 2000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          PHASE_COUNT   = 8;
    localparam int          PHASE_BEATS   = 235;

    // pt100 coefficients c0..c5, scaled by 2^40
    localparam longint PT100_COEF [6] = '{
        -64'sd266103804154348,
         64'sd2443994446220,
         64'sd2843227118,
        -64'sd5306243,
        -64'sd30988,
         64'sd168
    };

    class temperature_scoreboard;
        status_t             want_status [$];
        logic signed [15:0]  want_tenths [$];
        logic [15:0]         ref_res;
        int                  errors;

        function new();
            ref_res = REF_RES_RESET;
            errors  = 0;
        endfunction

        // product magnitude shifted right, truncated toward zero
        function automatic longint scaled_product(input longint a, input logic [63:0] m,
                                                  input int sh);
            logic [127:0] mag;
            logic [127:0] prod;
            mag  = (a < 0) ? 128'(0) - 128'(a) : 128'(a);
            prod = (mag * {64'd0, m}) >> sh;
            if (prod > 128'(64'h7FFF_FFFF_FFFF_FFFF))
                prod = 128'(64'h7FFF_FFFF_FFFF_FFFF);
            return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function automatic void convert(input logic [7:0] fault, input logic [15:0] word,
                                        output status_t st, output logic signed [15:0] t);
            logic [14:0] code;
            logic [63:0] ohms;
            longint      acc;
            longint      tenths;
            code = word[15:1];
            t    = '0;
            if (fault != 8'd0)
                st = STATUS_FAULT;
            else if (code == 15'd0)
                st = STATUS_ZERO;
            else
            begin
                st   = STATUS_VALID;
                ohms = ((64'(code) * 64'(ref_res)) << FRAC_BITS) / OHM_DIVISOR;
                acc  = PT100_COEF[5];
                for (int k = 4; k >= 0; k--)
                    acc = scaled_product(acc, ohms, FRAC_BITS) + PT100_COEF[k];
                tenths = scaled_product(acc, 64'd10, POLY_FRAC);
                if (tenths > 32767)
                    tenths = 32767;
                if (tenths < -32768)
                    tenths = -32768;
                t = tenths[15:0];
            end
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function automatic void note_input(input logic [7:0] fault, input logic [15:0] word);
            status_t            st;
            logic signed [15:0] t;
            convert(fault, word, st, t);
            want_status.push_back(st);
            want_tenths.push_back(t);
        endfunction

        task check_result(input logic [1:0] st, input logic signed [15:0] t);
            status_t            exp_st;
            logic signed [15:0] exp_t;
            if (want_status.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                exp_st = want_status.pop_front();
                exp_t  = want_tenths.pop_front();
                if (st !== exp_st)
                    report_mismatch($sformatf("status %0d, expected %0d", st, exp_st));
                if (t !== exp_t)
                    report_mismatch($sformatf("temperature %0d, expected %0d", t, exp_t));
            end
        endtask

        function automatic int pending();
            return want_status.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FAULT_W-1:0]        fault_status;
    logic [WORD_W-1:0]         rtd_word;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                result_status;
    logic signed [TEMP_W-1:0]  temperature_tenths;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [REF_W-1:0]          cfg_data;

    logic tx_idles;
    logic rx_stalls;
    int   idle_cycles = 0;

    temperature_scoreboard sb = new();

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rtd_ratio_to_temperature_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .fault_status       (fault_status),
        .rtd_word           (rtd_word),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result_status      (result_status),
        .temperature_tenths (temperature_tenths),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(fault_status, rtd_word);
            if (out_valid && out_ready)
                sb.check_result(result_status, temperature_tenths);
            if (cfg_valid && cfg_ready)
                sb.ref_res = cfg_data;
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("FAIL rtd_ratio_to_temperature_unit");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            hold = rx_stalls ? pick_gap() : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    task automatic send_beat(input logic [7:0] fault, input logic [15:0] word);
        int gap;
        gap = tx_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        fault_status <= fault;
        rtd_word     <= word;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reference(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] ref_list [PHASE_COUNT];
        logic [7:0]  fault;
        logic [15:0] word;
        int          roll;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        fault_status = '0;
        rtd_word     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        tx_idles     = 1'b1;
        rx_stalls    = 1'b1;
        ref_list = '{16'd65535, 16'd100, 16'd0, 16'd1, 16'd10000,
                     16'($urandom_range(100, 65535)), 16'd43000,
                     16'($urandom_range(0, 65535))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset reference, edges of the code and fault paths
        send_beat(8'h00, 16'h0000);
        send_beat(8'h00, 16'h0001);
        send_beat(8'h00, 16'h0002);
        send_beat(8'h00, 16'h0003);
        send_beat(8'h00, 16'hFFFF);
        send_beat(8'h00, 16'hFFFE);
        send_beat(8'h00, 16'h8000);
        send_beat(8'h00, 16'h7FFF);
        send_beat(8'h00, 16'd15240);
        send_beat(8'h00, 16'd20000);
        send_beat(8'hFF, 16'hFFFF);
        send_beat(8'h01, 16'h0000);
        send_beat(8'h80, 16'h1234);
        send_beat(8'h55, 16'hAAAA);
        send_beat(8'hAA, 16'h5555);
        send_beat(8'h04, 16'd15240);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_reference(ref_list[phase]);
            tx_idles  = (phase % 3) != 1;
            rx_stalls = (phase % 3) != 2;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (n == 0)
                begin
                    fault = 8'h00;
                    word  = 16'hFFFF;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 80)
                        fault = 8'h00;
                    else if (roll < 90)
                        fault = 8'(1 << $urandom_range(0, 7));
                    else
                        fault = 8'($urandom_range(1, 255));
                    roll = $urandom_range(0, 99);
                    if (roll < 4)
                        word = 16'($urandom_range(0, 1));
                    else if (roll < 10)
                        word = 16'hFFFF - 16'($urandom_range(0, 3));
                    else
                        word = 16'($urandom);
                end
                send_beat(fault, word);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS rtd_ratio_to_temperature_unit");
        else
            $display("FAIL rtd_ratio_to_temperature_unit");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rtd_pkg.sv
hw/rtl/rtd_horner_step.sv
hw/rtl/rtd_ratio_to_temperature_unit.sv
hw/rtl/rtd_chk.sv
tb/tb.sv
